// ----- rtl/core/proximity_collision_checker_assert.svh -----
// Assertion macros shared by the proximity collision checker RTL.
`ifndef PROXIMITY_COLLISION_CHECKER_ASSERT_SVH
`define PROXIMITY_COLLISION_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pcc_pkg.sv -----
// Package: shared types and constants of the proximity collision checker.
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

   localparam int TICK_W     = 4;
   localparam int OBJ_W      = 3;
   localparam int COORD_W    = 16;
   localparam int THRESH_W   = 36;
   localparam int SQ_W       = 32;   // square of a 17-bit difference, < 2^32
   localparam int ACC_W      = 34;   // sum of three squares, < 3 * 2^32
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 1;

   localparam logic [CSR_ADDR_W-1:0] THRESH_ADDR  = 1'b0;
   localparam logic [THRESH_W-1:0]   THRESH_RESET = 36'd256;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } coord3_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic     square_en;
      logic     acc_clear;
      logic     acc_add;
      axis_type axis;
   } sqacc_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/pcc_store.sv -----
// Position store: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pcc_store #(
   parameter int AW = 7
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire pcc_pkg::coord3_type    wr_data,
   input  wire logic                   rd_en,
   input  wire logic [AW-1:0]          rd_addr,
   output pcc_pkg::coord3_type         rd_data
);
   import pcc_pkg::*;

   localparam int DEPTH = 2 ** AW;

   coord3_type mem_ff [DEPTH];
   coord3_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pcc_sqacc.sv -----
// Shared square-accumulate unit: one axis square per cycle, sum, threshold compare.
`timescale 1ns / 1ps
`default_nettype none

module pcc_sqacc (
   input  wire logic                            clock,
   input  wire pcc_pkg::sqacc_ctrl_type         ctrl,
   input  wire pcc_pkg::coord3_type             cur,
   input  wire pcc_pkg::coord3_type             other,
   input  wire logic [pcc_pkg::THRESH_W-1:0]    thresh,
   output logic                                 hit
);
   import pcc_pkg::*;

   logic signed [COORD_W-1:0]   a_sel;
   logic signed [COORD_W-1:0]   b_sel;
   logic signed [COORD_W:0]     diff;
   logic signed [2*COORD_W+1:0] prod;
   logic [SQ_W-1:0]             sq_in;
   logic [SQ_W-1:0]             sq_ff;
   logic [ACC_W-1:0]            acc_in;
   logic [ACC_W-1:0]            acc_ff;

   always_comb begin
      case (ctrl.axis)
         AXIS_X: begin
            a_sel = cur.x;
            b_sel = other.x;
         end
         AXIS_Y: begin
            a_sel = cur.y;
            b_sel = other.y;
         end
         AXIS_Z: begin
            a_sel = cur.z;
            b_sel = other.z;
         end
         default: begin
            a_sel = cur.x;
            b_sel = other.x;
         end
      endcase
      diff  = {a_sel[COORD_W-1], a_sel} - {b_sel[COORD_W-1], b_sel};
      prod  = diff * diff;
      // |diff| <= 65535, so the square fits in 32 bits
      sq_in = prod[SQ_W-1:0];
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clear) begin
         acc_in = '0;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + {{(ACC_W-SQ_W){1'b0}}, sq_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.square_en) begin
         sq_ff <= sq_in;
      end
      acc_ff <= acc_in;
   end

   assign hit = {{(THRESH_W-ACC_W){1'b0}}, acc_ff} < thresh;

endmodule

`default_nettype wire

// ----- rtl/core/proximity_collision_checker.sv -----
// Top level: proximity collision checker with sequencer, CSR and response register.
`timescale 1ns / 1ps
`default_nettype none
`include "proximity_collision_checker_assert.svh"

// Proximity collision checker. Each request carries a tick, an object id and
// a Q11.4 position (x, y, z). The position is written into a store indexed
// by tick and object, then compared against the stored position of every
// lower-numbered object at the same tick, in ascending id order. A pair
// collides when the squared distance (1/256 units) is strictly below
// threshold_squared (CSR at address 0, reset 256 = distance 1.0). Each
// collision yields one response naming the other object; tlast marks the
// final response of the request. Requests with tick >= TICKS or
// object_id >= OBJECTS are dropped without a store write, as are responses
// for object zero or when nothing collides.
// Sequencing: one shared square-accumulate unit handles one axis per cycle, so
// each pair passes through store read, three squares, final add and compare.
// A request holds the block for its whole scan, and longer while the response
// side stalls. After reset the store is cleared one entry per cycle, all
// 2^(TW+OW) entries (128 with default parameters), during which req_tready stays
// low; CSR writes are taken throughout.
// Responses sit in an output register, so a new request may be taken while
// the last response of the previous one is still waiting.
module proximity_collision_checker #(
   parameter int OBJECTS = 8,
   parameter int TICKS   = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request: [3:0] tick, [6:4] object_id, [22:7] pos_x, [38:23] pos_y,
   //          [54:39] pos_z, [55] zero pad
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [pcc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response: [3:0] hit_tick, [6:4] hit_object, [9:7] other_object,
   //           [15:10] zero pad; tlast is last_hit
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [pcc_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                     rsp_tlast,
   // CSR port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pcc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [pcc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pcc_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);
   import pcc_pkg::*;

   // Only ids the request fields can carry need storage.
   localparam int TICK_CODES = 2 ** TICK_W;
   localparam int OBJ_CODES  = 2 ** OBJ_W;
   localparam int TICK_N     = (TICKS < TICK_CODES) ? TICKS : TICK_CODES;
   localparam int OBJ_N      = (OBJECTS < OBJ_CODES) ? OBJECTS : OBJ_CODES;
   localparam int TW         = (TICK_N > 1) ? $clog2(TICK_N) : 1;
   localparam int OW         = (OBJ_N > 1) ? $clog2(OBJ_N) : 1;
   localparam int AW         = TW + OW;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_FETCH = 7'b0000100,
      ST_SQ    = 7'b0001000,
      ST_SUM   = 7'b0010000,
      ST_CHECK = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // request fields
   logic [TICK_W-1:0] req_tick;
   logic [OBJ_W-1:0]  req_obj;
   coord3_type        req_pos;

   assign req_tick  = req_tdata[3:0];
   assign req_obj   = req_tdata[6:4];
   assign req_pos.x = req_tdata[22:7];
   assign req_pos.y = req_tdata[38:23];
   assign req_pos.z = req_tdata[54:39];

   // control state
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [OW-1:0]     idx_ff, idx_in;
   axis_type          axis_ff, axis_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;

   // payload
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [OBJ_W-1:0]  obj_ff, obj_in;
   coord3_type        cur_ff, cur_in;
   logic [OW-1:0]     pend_other_ff, pend_other_in;
   logic [TICK_W-1:0] rsp_tick_ff, rsp_tick_in;
   logic [OBJ_W-1:0]  rsp_obj_ff, rsp_obj_in;
   logic [OBJ_W-1:0]  rsp_other_ff, rsp_other_in;
   logic              rsp_last_ff, rsp_last_in;

   // datapath hookup
   logic              req_accept;
   logic              tick_ok;
   logic              obj_ok;
   logic              out_free;
   logic              hit;
   logic [OW-1:0]     last_idx;
   logic              push;
   logic [OW-1:0]     push_other;
   logic              push_last;
   logic              st_wr_en;
   logic [AW-1:0]     st_wr_addr;
   coord3_type        st_wr_data;
   logic              st_rd_en;
   logic [AW-1:0]     st_rd_addr;
   coord3_type        st_rd_data;
   sqacc_ctrl_type    sq_ctrl;
   logic              csr_write;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign tick_ok    = {28'd0, req_tick} < 32'(TICKS);
   assign obj_ok     = {29'd0, req_obj} < 32'(OBJECTS);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_idx   = obj_ff[OW-1:0] - OW'(1);
   assign st_rd_en   = (state_ff == ST_FETCH);
   assign st_rd_addr = {tick_ff[TW-1:0], idx_ff};

   // CSR: single threshold register, always ready
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == THRESH_ADDR);
   assign thresh_in  = csr_write ? csr_pwdata[THRESH_W-1:0] : thresh_ff;
   assign csr_prdata = (csr_paddr == THRESH_ADDR)
                       ? {{(CSR_DATA_W-THRESH_W){1'b0}}, thresh_ff} : '0;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      idx_in        = idx_ff;
      axis_in       = axis_ff;
      pend_valid_in = pend_valid_ff;
      pend_other_in = pend_other_ff;
      tick_in       = tick_ff;
      obj_in        = obj_ff;
      cur_in        = cur_ff;
      sq_ctrl       = '0;
      st_wr_en      = 1'b0;
      st_wr_addr    = {req_tick[TW-1:0], req_obj[OW-1:0]};
      st_wr_data    = req_pos;
      push          = 1'b0;
      push_other    = pend_other_ff;
      push_last     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            st_wr_en    = 1'b1;
            st_wr_addr  = clr_addr_ff;
            st_wr_data  = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               tick_in = req_tick;
               obj_in  = req_obj;
               cur_in  = req_pos;
               idx_in  = '0;
               if (tick_ok && obj_ok) begin
                  st_wr_en = 1'b1;
                  if (req_obj != '0) begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            axis_in  = AXIS_X;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sq_ctrl.square_en = 1'b1;
            sq_ctrl.axis      = axis_ff;
            // first axis restarts the sum, later ones add the previous square
            if (axis_ff == AXIS_X) begin
               sq_ctrl.acc_clear = 1'b1;
            end else begin
               sq_ctrl.acc_add = 1'b1;
            end
            case (axis_ff)
               AXIS_X:  axis_in = AXIS_Y;
               AXIS_Y:  axis_in = AXIS_Z;
               default: state_in = ST_SUM;
            endcase
         end
         ST_SUM: begin
            sq_ctrl.acc_add = 1'b1;
            state_in        = ST_CHECK;
         end
         ST_CHECK: begin
            // a new hit needs the held one sent first
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_other_in = idx_ff;
               end
               if (idx_ff == last_idx) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + OW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_tick_in  = rsp_tick_ff;
      rsp_obj_in   = rsp_obj_ff;
      rsp_other_in = rsp_other_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_tick_in  = tick_ff;
         rsp_obj_in   = obj_ff;
         rsp_other_in = OBJ_W'(push_other);
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         idx_ff        <= '0;
         axis_ff       <= AXIS_X;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thresh_ff     <= THRESH_RESET;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         idx_ff        <= idx_in;
         axis_ff       <= axis_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         thresh_ff     <= thresh_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff       <= tick_in;
      obj_ff        <= obj_in;
      cur_ff        <= cur_in;
      pend_other_ff <= pend_other_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_obj_ff    <= rsp_obj_in;
      rsp_other_ff  <= rsp_other_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TICK_W-2*OBJ_W){1'b0}},
                        rsp_other_ff, rsp_obj_ff, rsp_tick_ff};

   pcc_store #(
      .AW (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   pcc_sqacc u_sqacc (
      .clock  (clock),
      .ctrl   (sq_ctrl),
      .cur    (cur_ff),
      .other  (st_rd_data),
      .thresh (thresh_ff),
      .hit    (hit)
   );

   `PCC_ASSERT_NOW(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !req_tready && !rsp_tvalid, "request or response active during store clear")
   `PCC_ASSERT_NOW(a_other_lower, clock, reset, rsp_valid_ff, rsp_other_ff < rsp_obj_ff, "response names an object not below the reporter")
   `PCC_ASSERT_NEXT(a_scan_starts, clock, reset, req_accept && tick_ok && obj_ok && (req_obj != '0), state_ff == ST_FETCH, "accepted request did not start the scan")
   `PCC_ASSERT_NOW(a_pend_in_scan, clock, reset, pend_valid_ff, state_ff != ST_IDLE && state_ff != ST_CLEAR, "held hit left behind after the scan")
   `PCC_ASSERT_NEXT(a_done_empty, clock, reset, state_ff == ST_DONE && !pend_valid_ff, state_ff == ST_IDLE, "scan without hits did not return to idle")

endmodule

`default_nettype wire
